/* rtl/sjq_pkg.sv */
// sjq_pkg: types, constants and helper functions for the stable priority job queue
// used by the channel interfaces, the queue cell and the top level

package sjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_CNT_W   = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_DEQUEUE  = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;
    localparam logic [1:0] OP_RESET    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_ALL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALL = 1'b1;

    localparam logic [2:0] CMD_HOLD  = 3'd0;
    localparam logic [2:0] CMD_LATCH = 3'd1;
    localparam logic [2:0] CMD_ENQ   = 3'd2;
    localparam logic [2:0] CMD_DEQ   = 3'd3;
    localparam logic [2:0] CMD_BUMP  = 3'd4;
    localparam logic [2:0] CMD_DROP  = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  job_kind;
        logic [15:0] blk_addr;
        logic [7:0]  priority_req;
        logic        urgent;
        logic [31:0] timeout_limit;
        logic [31:0] submit_time;
        logic [7:0]  retries_so_far;
        logic [7:0]  retry_limit;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [3:0]  out_job_kind;
        logic [15:0] out_blk_addr;
        logic [7:0]  out_priority;
        logic        out_immediate;
        logic [31:0] out_timeout_limit;
        logic [31:0] out_submit_time;
        logic [7:0]  out_retries;
        logic [7:0]  out_retry_limit;
        logic [4:0]  depth;
        logic [4:0]  high_water;
        logic [4:0]  removed_count;
    } t_res;

    typedef struct packed {
        logic [3:0]  job_kind;
        logic [15:0] blk_addr;
        logic [7:0]  priority_req;
        logic        urgent;
        logic [31:0] timeout_limit;
        logic [31:0] submit_time;
        logic [7:0]  retries;
        logic [7:0]  retry_limit;
    } t_entry;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  np;
        logic [31:0] now;
        logic [3:0]  rd_type;
        logic [3:0]  wr_type;
    } t_cell_ctl;

    function automatic logic [7:0] eff_prio(
        input logic [3:0] jt,
        input logic [7:0] pr,
        input logic       imm,
        input logic [3:0] rd,
        input logic [3:0] wr
    );
        logic [7:0] res;
        if (jt == rd) begin
            res = 8'd0;
        end else if (jt == wr) begin
            res = 8'd1;
        end else if (imm && (pr > 8'd2)) begin
            res = pr - 8'd2;
        end else begin
            res = pr;
        end
        return res;
    endfunction

endpackage

/* rtl/sjq_req_if.sv */
// sjq_req_if: request channel carrying one queue operation per transfer
// depends on sjq_pkg

interface sjq_req_if;
    import sjq_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

/* rtl/sjq_res_if.sv */
// sjq_res_if: result channel carrying one result per transfer
// depends on sjq_pkg

interface sjq_res_if;
    import sjq_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

/* rtl/sjq_cell.sv */
// sjq_cell: one queue slot, holds a job and its compare and timeout flags
// shifts to and from its neighbours on command; depends on sjq_pkg

module sjq_cell (
    input  logic               i_clk,
    input  sjq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  logic               i_tail,
    input  sjq_pkg::t_entry    i_new,
    input  sjq_pkg::t_entry    i_left,
    input  sjq_pkg::t_entry    i_right,
    input  logic               i_right_drop,
    input  logic               i_found,
    input  logic               i_dseen,
    output sjq_pkg::t_entry    o_entry,
    output logic               o_drop,
    output logic               o_found,
    output logic               o_dseen
);
    import sjq_pkg::*;

    t_entry      r_entry;
    logic        r_gt;
    logic        r_exp;
    logic        r_drop;
    logic [7:0]  w_eff;
    logic [31:0] w_elapsed;
    logic        w_exp;
    logic [7:0]  w_retry_inc;

    assign w_eff = eff_prio(r_entry.job_kind, r_entry.priority_req, r_entry.urgent,
                            i_ctl.rd_type, i_ctl.wr_type);
    assign w_elapsed   = i_ctl.now - r_entry.submit_time;
    assign w_exp       = i_occ && (r_entry.timeout_limit != 32'd0)
                         && (w_elapsed > r_entry.timeout_limit);
    assign w_retry_inc = r_entry.retries + 8'd1;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LATCH: begin
                r_gt   <= i_occ && (i_ctl.np < w_eff);
                r_exp  <= w_exp;
                r_drop <= w_exp && (w_retry_inc > r_entry.retry_limit);
            end
            CMD_ENQ: begin
                if (i_found) begin
                    r_entry <= i_left;
                end else if (r_gt || i_tail) begin
                    r_entry <= i_new;
                end
            end
            CMD_DEQ: begin
                r_entry <= i_right;
            end
            CMD_BUMP: begin
                if (r_exp) begin
                    r_entry.retries <= w_retry_inc;
                end
            end
            CMD_DROP: begin
                if (i_dseen || r_drop) begin
                    r_entry <= i_right;
                    r_drop  <= i_right_drop;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_drop  = r_drop;
    assign o_found = i_found | r_gt;
    assign o_dseen = i_dseen | r_drop;

endmodule

/* rtl/stable_priority_job_queue.sv */
// stable_priority_job_queue: sorted job queue built from a row of sjq_cell slots
// depends on sjq_pkg, sjq_req_if, sjq_res_if and sjq_cell
//
// usage: one request transfer on i_req carries an operation (enqueue, dequeue,
// check timeouts, reset queue) and its job fields; exactly one result transfer
// on o_res follows for each request, in order.
// steps: enqueue, dequeue and reset latch the request, then finish in the apply
// step, which loads the result register; check timeouts bumps retry counts in
// the apply step, then drops expired jobs in the scan step as the cell row
// closes one gap per cycle, and loads the result once no drop is left.
// a new request is taken only once the previous one has finished.
// the result sits in an output register; the next request is taken while it
// waits, and only the finishing step of the following item holds off until
// o_res.ready frees that register.
// i_cfg_we with i_cfg_idx 0 writes the read-all type code, index 1 the
// write-all type code; write only while no request is in progress.
// reset (i_rst_n low, synchronous) empties the queue, clears the high-water
// mark and sets the type codes to 0 and 1. the reset-queue operation empties
// the queue but keeps the high-water mark.

module stable_priority_job_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sjq_req_if.sink                         i_req,
    sjq_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [sjq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sjq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sjq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_op;
    t_entry           r_job;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_hw, n_hw;
    logic [CNT_W-1:0] r_removed, n_removed;
    logic [3:0]       r_rd_type;
    logic [3:0]       r_wr_type;
    logic             r_res_valid, n_res_valid;
    t_res             r_res, n_res;

    t_cell_ctl              w_ctl;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_load;
    logic                   w_status;
    logic                   w_any_drop;
    logic [CNT_W+4:0]       w_occ_ext;
    logic [CNT_W+4:0]       w_hw_ext;
    logic [CNT_W+4:0]       w_rem_ext;
    t_entry                 w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_drop;
    logic [QUEUE_DEPTH:0]   w_found;
    logic [QUEUE_DEPTH:0]   w_dseen;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_res_valid || o_res.ready;
    assign w_any_drop  = w_dseen[QUEUE_DEPTH];
    assign w_found[0]  = 1'b0;
    assign w_dseen[0]  = 1'b0;

    always_comb begin
        w_ctl.np      = eff_prio(i_req.payload.job_kind, i_req.payload.priority_req,
                                 i_req.payload.urgent, r_rd_type, r_wr_type);
        w_ctl.now     = i_req.payload.now_ms;
        w_ctl.rd_type = r_rd_type;
        w_ctl.wr_type = r_wr_type;
        w_ctl.cmd     = CMD_HOLD;
        n_state       = r_state;
        n_occ         = r_occ;
        n_hw          = r_hw;
        n_removed     = r_removed;
        w_load        = 1'b0;
        w_status      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctl.cmd = CMD_LATCH;
                    n_removed = '0;
                    n_state   = ST_APPLY;
                end
            end
            ST_APPLY: begin
                case (r_op)
                    OP_ENQUEUE: begin
                        if (w_out_free) begin
                            w_load  = 1'b1;
                            n_state = ST_IDLE;
                            if (r_occ == CNT_W'(QUEUE_DEPTH)) begin
                                w_status = 1'b1;
                            end else begin
                                w_ctl.cmd = CMD_ENQ;
                                n_occ     = r_occ + 1'b1;
                                if (n_occ > r_hw) begin
                                    n_hw = n_occ;
                                end
                            end
                        end
                    end
                    OP_DEQUEUE: begin
                        if (w_out_free) begin
                            w_load  = 1'b1;
                            n_state = ST_IDLE;
                            if (r_occ == '0) begin
                                w_status = 1'b1;
                            end else begin
                                w_ctl.cmd = CMD_DEQ;
                                n_occ     = r_occ - 1'b1;
                            end
                        end
                    end
                    OP_CHECK: begin
                        w_ctl.cmd = CMD_BUMP;
                        n_state   = ST_SCAN;
                    end
                    OP_RESET: begin
                        if (w_out_free) begin
                            w_load  = 1'b1;
                            n_state = ST_IDLE;
                            n_occ   = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                if (w_any_drop) begin
                    w_ctl.cmd = CMD_DROP;
                    n_occ     = r_occ - 1'b1;
                    n_removed = r_removed + 1'b1;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_occ_ext = {5'd0, n_occ};
    assign w_hw_ext  = {5'd0, n_hw};
    assign w_rem_ext = {5'd0, n_removed};

    always_comb begin
        n_res               = '0;
        n_res.status        = w_status;
        n_res.depth         = w_occ_ext[OUT_CNT_W-1:0];
        n_res.high_water    = w_hw_ext[OUT_CNT_W-1:0];
        n_res.removed_count = w_rem_ext[OUT_CNT_W-1:0];
        if ((r_op == OP_DEQUEUE) && !w_status) begin
            n_res.out_job_kind      = w_entry[0].job_kind;
            n_res.out_blk_addr      = w_entry[0].blk_addr;
            n_res.out_priority      = w_entry[0].priority_req;
            n_res.out_immediate     = w_entry[0].urgent;
            n_res.out_timeout_limit = w_entry[0].timeout_limit;
            n_res.out_submit_time   = w_entry[0].submit_time;
            n_res.out_retries       = w_entry[0].retries;
            n_res.out_retry_limit   = w_entry[0].retry_limit;
        end
        n_res_valid = w_load || (r_res_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_hw        <= '0;
            r_removed   <= '0;
            r_rd_type   <= 4'd0;
            r_wr_type   <= 4'd1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_hw        <= n_hw;
            r_removed   <= n_removed;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_READ_ALL:  r_rd_type <= i_cfg_data;
                    CFG_WRITE_ALL: r_wr_type <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op                <= i_req.payload.operation;
            r_job.job_kind      <= i_req.payload.job_kind;
            r_job.blk_addr      <= i_req.payload.blk_addr;
            r_job.priority_req  <= i_req.payload.priority_req;
            r_job.urgent        <= i_req.payload.urgent;
            r_job.timeout_limit <= i_req.payload.timeout_limit;
            r_job.submit_time   <= i_req.payload.submit_time;
            r_job.retries       <= i_req.payload.retries_so_far;
            r_job.retry_limit   <= i_req.payload.retry_limit;
        end
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_right;
        logic   w_right_drop;
        t_entry w_left;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right      = w_entry[g];
            assign w_right_drop = 1'b0;
        end else begin : g_mid
            assign w_right      = w_entry[g+1];
            assign w_right_drop = w_drop[g+1];
        end
        if (g == 0) begin : g_first
            assign w_left = r_job;
        end else begin : g_rest
            assign w_left = w_entry[g-1];
        end
        sjq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (CNT_W'(g) < r_occ),
            .i_tail       (CNT_W'(g) == r_occ),
            .i_new        (r_job),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_right_drop (w_right_drop),
            .i_found      (w_found[g]),
            .i_dseen      (w_dseen[g]),
            .o_entry      (w_entry[g]),
            .o_drop       (w_drop[g]),
            .o_found      (w_found[g+1]),
            .o_dseen      (w_dseen[g+1])
        );
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");
    a_hw_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw >= r_occ)
        else $error("high-water mark below occupancy");
    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && w_any_drop |-> r_occ != '0)
        else $error("drop requested on empty queue");
    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_APPLY)
        else $error("transfer not followed by apply step");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over a waiting result");
`endif

endmodule
